/* hw/rtl/tpcr_pkg.sv */
// ----------------------------------------------------------------------------
// tpcr_pkg
// Shared types and constants for the touch point calibrate and rotate block.
// ----------------------------------------------------------------------------
package tpcr_pkg;

  // screen dimension registers and the scaled coordinate before clamping
  localparam int DIM_BITS = 11;
  localparam int CNT_BITS = 4;
  localparam int TIME_BITS = 32;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_INDEX_BITS = 3;

  localparam int RAW_LOW_RESET = 200;
  localparam int RAW_HIGH_RESET = 3900;
  localparam int WIDTH_RESET = 320;
  localparam int HEIGHT_RESET = 240;
  localparam int ORIENT_RESET = 1;
  localparam int DEBOUNCE_RESET = 250;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_RAW_X_LOW,
    REG_RAW_X_HIGH,
    REG_RAW_Y_LOW,
    REG_RAW_Y_HIGH,
    REG_SCREEN_WIDTH,
    REG_SCREEN_HEIGHT,
    REG_ORIENTATION,
    REG_DEBOUNCE_DELAY
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ORIENT_0,
    ORIENT_90,
    ORIENT_180,
    ORIENT_270
  } orient_t;

  typedef struct packed {
    logic busy;
    logic done;
  } scale_stat_t;

endpackage

/* hw/rtl/touch_point_calibrate_rotate_core.sv */
// ----------------------------------------------------------------------------
// touch_point_calibrate_rotate_core
// Debounces and windows a touch sample, scales it to screen coordinates,
// rotates and clamps it.
// ----------------------------------------------------------------------------
// Sequence: an accepted sample is checked, each axis in turn passes the shared
//   scaler, then the point is rotated and clamped; a rejected sample goes
//   straight out. An axis with a zero span or a zero size skips the divide.
// One sample at a time: the next request is taken once the last result is in
//   the output register, while that result still waits there.
// Reset: synchronous; configuration registers return to their defaults, last touch time 0.
// ----------------------------------------------------------------------------
module touch_point_calibrate_rotate_core #(
  parameter int RAW_BITS   = 12,
  parameter int COORD_BITS = 10
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [tpcr_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [tpcr_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // raw_x, raw_y, now_ms, zero fill
  input  logic [((2*RAW_BITS+32+7)/8)*8-1:0]    s_tdata,
  // pressed
  input  logic                                  s_tuser,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // screen_x, screen_y, zero fill
  output logic [((2*COORD_BITS+7)/8)*8-1:0]     m_tdata,
  // point_valid
  output logic                                  m_tuser
);

  localparam int DB = tpcr_pkg::DIM_BITS;
  localparam int TB = tpcr_pkg::TIME_BITS;
  localparam int OUT_W = ((2*COORD_BITS+7)/8)*8;
  localparam int COORD_MAX = (1 << COORD_BITS) - 1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHECK, ST_AXIS_X, ST_WAIT_X, ST_AXIS_Y, ST_WAIT_Y, ST_ROTATE, ST_FINISH
  } state_t;

  state_t                     state;
  logic [RAW_BITS-1:0]        x_low, x_high, y_low, y_high;
  logic [DB-1:0]              scr_w, scr_h;
  tpcr_pkg::orient_t          orient;
  logic [TB-1:0]              debounce;
  logic [TB-1:0]              last_t;

  logic                       in_pressed;
  logic [RAW_BITS-1:0]        in_x, in_y;
  logic [TB-1:0]              in_now;

  logic signed [DB+1:0]       mx, my;
  logic                       res_valid;
  logic [COORD_BITS-1:0]      res_x, res_y;

  logic                       sel_y;
  logic [RAW_BITS-1:0]        cur_raw, cur_lo, cur_hi, cur_span, cur_diff;
  logic [DB-1:0]              cur_size;
  logic                       need_div;
  logic signed [DB+1:0]       direct_val;
  logic                       win_ok, time_ok;
  logic signed [DB+1:0]       w_s, h_s, rot_x, rot_y;
  logic                       rotated;
  logic [COORD_BITS-1:0]      clamp_x, clamp_y;
  logic                       out_load;

  logic                       su_start;
  logic [DB-1:0]              su_quot;
  tpcr_pkg::scale_stat_t      su_stat;

  function automatic logic [COORD_BITS-1:0] clamp_coord(input logic signed [DB+1:0] v,
                                                         input logic [DB-1:0] size);
    logic [DB-1:0] szm1;
    logic [DB-1:0] top;
    logic [COORD_BITS-1:0] r;
    szm1 = size - 1'b1;
    top  = (32'(szm1) > COORD_MAX) ? DB'(COORD_MAX) : szm1;
    if (size == '0 || v < 0) begin
      r = '0;
    end else if (v > $signed({2'b00, top})) begin
      r = COORD_BITS'(top);
    end else begin
      r = COORD_BITS'(v);
    end
    return r;
  endfunction

  assign s_tready = (state == ST_IDLE);
  assign out_load = (state == ST_FINISH) && (!m_tvalid || m_tready);

  // per-axis operand selection
  assign sel_y     = (state == ST_AXIS_Y);
  assign cur_raw   = sel_y ? in_y : in_x;
  assign cur_lo    = sel_y ? y_low : x_low;
  assign cur_hi    = sel_y ? y_high : x_high;
  assign cur_size  = sel_y ? scr_h : scr_w;
  assign cur_span  = cur_hi - cur_lo;
  assign cur_diff  = cur_raw - cur_lo;
  assign need_div  = (cur_span != '0) && (cur_size != '0);
  assign direct_val = (cur_size == '0 && cur_span != '0 && cur_raw == cur_hi) ?
                      -(DB+2)'(1) : '0;
  assign su_start  = (state == ST_AXIS_X || state == ST_AXIS_Y) && need_div;

  assign win_ok  = (in_x >= x_low) && (in_x <= x_high) && (in_y >= y_low) && (in_y <= y_high);
  assign time_ok = (in_now - last_t) >= debounce;

  assign w_s     = $signed({2'b00, scr_w});
  assign h_s     = $signed({2'b00, scr_h});
  assign rotated = (orient == tpcr_pkg::ORIENT_90) || (orient == tpcr_pkg::ORIENT_270);

  always_comb begin
    unique case (orient)
      tpcr_pkg::ORIENT_90: begin
        rot_x = h_s - (DB+2)'(1) - my;
        rot_y = mx;
      end
      tpcr_pkg::ORIENT_180: begin
        rot_x = w_s - (DB+2)'(1) - mx;
        rot_y = h_s - (DB+2)'(1) - my;
      end
      tpcr_pkg::ORIENT_270: begin
        rot_x = my;
        rot_y = w_s - (DB+2)'(1) - mx;
      end
      default: begin
        rot_x = mx;
        rot_y = my;
      end
    endcase
  end

  assign clamp_x = clamp_coord(rot_x, rotated ? scr_h : scr_w);
  assign clamp_y = clamp_coord(rot_y, rotated ? scr_w : scr_h);

  tpcr_scale_unit #(
    .RAW_BITS (RAW_BITS)
  ) u_scale (
    .clk    (clk),
    .rst    (rst),
    .start  (su_start),
    .diff   (cur_diff),
    .factor (cur_size - 1'b1),
    .span   (cur_span),
    .quot   (su_quot),
    .stat   (su_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      last_t   <= '0;
      x_low    <= RAW_BITS'(tpcr_pkg::RAW_LOW_RESET);
      x_high   <= RAW_BITS'(tpcr_pkg::RAW_HIGH_RESET);
      y_low    <= RAW_BITS'(tpcr_pkg::RAW_LOW_RESET);
      y_high   <= RAW_BITS'(tpcr_pkg::RAW_HIGH_RESET);
      scr_w    <= DB'(tpcr_pkg::WIDTH_RESET);
      scr_h    <= DB'(tpcr_pkg::HEIGHT_RESET);
      orient   <= tpcr_pkg::orient_t'(tpcr_pkg::ORIENT_RESET);
      debounce <= TB'(tpcr_pkg::DEBOUNCE_RESET);
    end else begin
      if (cfg_we) begin
        unique case (tpcr_pkg::cfg_reg_t'(cfg_index))
          tpcr_pkg::REG_RAW_X_LOW:      x_low    <= cfg_data[RAW_BITS-1:0];
          tpcr_pkg::REG_RAW_X_HIGH:     x_high   <= cfg_data[RAW_BITS-1:0];
          tpcr_pkg::REG_RAW_Y_LOW:      y_low    <= cfg_data[RAW_BITS-1:0];
          tpcr_pkg::REG_RAW_Y_HIGH:     y_high   <= cfg_data[RAW_BITS-1:0];
          tpcr_pkg::REG_SCREEN_WIDTH:   scr_w    <= cfg_data[DB-1:0];
          tpcr_pkg::REG_SCREEN_HEIGHT:  scr_h    <= cfg_data[DB-1:0];
          tpcr_pkg::REG_ORIENTATION:    orient   <= tpcr_pkg::orient_t'(cfg_data[1:0]);
          tpcr_pkg::REG_DEBOUNCE_DELAY: debounce <= cfg_data[TB-1:0];
          default: ;
        endcase
      end

      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            in_pressed <= s_tuser;
            in_x       <= s_tdata[RAW_BITS-1:0];
            in_y       <= s_tdata[2*RAW_BITS-1:RAW_BITS];
            in_now     <= s_tdata[2*RAW_BITS+TB-1:2*RAW_BITS];
            state      <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (in_pressed && time_ok && win_ok) begin
            last_t <= in_now;
            state  <= ST_AXIS_X;
          end else begin
            res_valid <= 1'b0;
            res_x     <= '0;
            res_y     <= '0;
            state     <= ST_FINISH;
          end
        end
        ST_AXIS_X: begin
          mx    <= direct_val;
          state <= need_div ? ST_WAIT_X : ST_AXIS_Y;
        end
        ST_WAIT_X: begin
          if (su_stat.done) begin
            mx    <= $signed({2'b00, su_quot});
            state <= ST_AXIS_Y;
          end
        end
        ST_AXIS_Y: begin
          my    <= direct_val;
          state <= need_div ? ST_WAIT_Y : ST_ROTATE;
        end
        ST_WAIT_Y: begin
          if (su_stat.done) begin
            my    <= $signed({2'b00, su_quot});
            state <= ST_ROTATE;
          end
        end
        ST_ROTATE: begin
          res_valid <= 1'b1;
          res_x     <= clamp_x;
          res_y     <= clamp_y;
          state     <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_load) begin
            m_tuser  <= res_valid;
            m_tdata  <= OUT_W'({res_y, res_x});
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_last_time_only_on_check: assert property (@(posedge clk) disable iff (rst)
    (state != ST_CHECK) |=> $stable(last_t))
    else $error("last touch time moved outside the acceptance check");

  a_rejected_is_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == '0))
    else $error("rejected sample carries non-zero coordinates");

  a_scale_done_when_waiting: assert property (@(posedge clk) disable iff (rst)
    su_stat.done |-> (state == ST_WAIT_X || state == ST_WAIT_Y))
    else $error("scaler finished with no axis waiting");

  a_scale_busy_when_waiting: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WAIT_X || state == ST_WAIT_Y) |-> (su_stat.busy || su_stat.done))
    else $error("axis waiting on an idle scaler");
`endif

endmodule

/* hw/rtl/tpcr_scale_unit.sv */
// ----------------------------------------------------------------------------
// tpcr_scale_unit
// Shared scaler: multiplies an offset by (size - 1), then divides by the
// calibration span with a restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tpcr_scale_unit #(
  parameter int RAW_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [RAW_BITS-1:0]               diff,
  input  logic [tpcr_pkg::DIM_BITS-1:0]     factor,
  input  logic [RAW_BITS-1:0]               span,
  output logic [tpcr_pkg::DIM_BITS-1:0]     quot,
  output tpcr_pkg::scale_stat_t             stat
);

  localparam int DB = tpcr_pkg::DIM_BITS;
  localparam int PW = RAW_BITS + DB;

  typedef enum logic [1:0] {SU_IDLE, SU_MUL, SU_DIV} su_state_t;

  su_state_t                     state;
  logic [RAW_BITS-1:0]           a_op;
  logic [DB-1:0]                 b_op;
  logic [RAW_BITS-1:0]           divisor;
  logic [RAW_BITS-1:0]           rem;
  logic [DB-1:0]                 low_bits;
  logic [tpcr_pkg::CNT_BITS-1:0] cnt;
  logic                          done;
  logic [PW-1:0]                 prod;
  logic [RAW_BITS:0]             trial;
  logic [RAW_BITS:0]             trial_sub;
  logic                          ge;

  assign prod      = PW'(a_op) * PW'(b_op);
  assign trial     = {rem, low_bits[DB-1]};
  assign trial_sub = trial - {1'b0, divisor};
  assign ge        = trial >= {1'b0, divisor};

  assign stat.busy = (state != SU_IDLE);
  assign stat.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SU_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        SU_IDLE: begin
          if (start) begin
            a_op    <= diff;
            b_op    <= factor;
            divisor <= span;
            state   <= SU_MUL;
          end
        end
        SU_MUL: begin
          // quotient never exceeds size - 1, so the top part is below the span
          rem      <= prod[PW-1:DB];
          low_bits <= prod[DB-1:0];
          cnt      <= '0;
          state    <= SU_DIV;
        end
        SU_DIV: begin
          rem      <= ge ? trial_sub[RAW_BITS-1:0] : trial[RAW_BITS-1:0];
          low_bits <= {low_bits[DB-2:0], 1'b0};
          quot     <= {quot[DB-2:0], ge};
          if (cnt == tpcr_pkg::CNT_BITS'(DB - 1)) begin
            done  <= 1'b1;
            state <= SU_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        default: state <= SU_IDLE;
      endcase
    end
  end

endmodule

/* tb/tb_touch_point_calibrate_rotate_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_touch_point_calibrate_rotate_core
// Drives touch samples through the calibrate and rotate core, predicts each
// screen point from its own copy of the calibration registers and the last
// touch time, and compares every output point field by field, in order.
// Directed samples cover the window and debounce edges, each rotation and
// odd register settings; random phases follow, with a receiver hold-off.
// ----------------------------------------------------------------------------
module tb_touch_point_calibrate_rotate_core;

  localparam int RAW_BITS      = 12;
  localparam int COORD_BITS    = 10;
  localparam int DIM_BITS      = tpcr_pkg::DIM_BITS;
  localparam int COORD_MAX     = (1 << COORD_BITS) - 1;
  localparam int S_DATA_W      = ((2*RAW_BITS+32+7)/8)*8;
  localparam int M_DATA_W      = ((2*COORD_BITS+7)/8)*8;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 400000;

  typedef struct {
    logic [RAW_BITS-1:0] x_low;
    logic [RAW_BITS-1:0] x_high;
    logic [RAW_BITS-1:0] y_low;
    logic [RAW_BITS-1:0] y_high;
    logic [DIM_BITS-1:0] width;
    logic [DIM_BITS-1:0] height;
    tpcr_pkg::orient_t   orient;
    logic [31:0]         debounce_gap;
  } cal_cfg_t;

  typedef struct packed {
    logic                  valid;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } touch_point_t;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                cfg_we = 1'b0;
  logic [tpcr_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [tpcr_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;
  logic                                s_tvalid = 1'b0;
  logic                                s_tready;
  logic [S_DATA_W-1:0]                 s_tdata = '0;
  logic                                s_tuser = 1'b0;
  logic                                m_tvalid;
  logic                                m_tready = 1'b0;
  logic [M_DATA_W-1:0]                 m_tdata;
  logic                                m_tuser;

  cal_cfg_t     cal;
  logic [31:0]  last_touch_ms = '0;
  touch_point_t expected_points[$];
  touch_point_t oldest;
  int           mismatch_count = 0;
  int           cycle_count = 0;
  int           gap_pct = 19;
  int           stall_pct = 19;
  logic         hold_req = 1'b0;

  touch_point_calibrate_rotate_core #(
    .RAW_BITS  (RAW_BITS),
    .COORD_BITS(COORD_BITS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever begin
      #5 clk = ~clk;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic cal_cfg_t default_cal();
    cal_cfg_t c;
    c.x_low        = RAW_BITS'(tpcr_pkg::RAW_LOW_RESET);
    c.x_high       = RAW_BITS'(tpcr_pkg::RAW_HIGH_RESET);
    c.y_low        = RAW_BITS'(tpcr_pkg::RAW_LOW_RESET);
    c.y_high       = RAW_BITS'(tpcr_pkg::RAW_HIGH_RESET);
    c.width        = DIM_BITS'(tpcr_pkg::WIDTH_RESET);
    c.height       = DIM_BITS'(tpcr_pkg::HEIGHT_RESET);
    c.orient       = tpcr_pkg::orient_t'(tpcr_pkg::ORIENT_RESET);
    c.debounce_gap = 32'(tpcr_pkg::DEBOUNCE_RESET);
    return c;
  endfunction

  function automatic longint scale_axis(logic [RAW_BITS-1:0] raw, logic [RAW_BITS-1:0] lo,
                                        logic [RAW_BITS-1:0] hi, logic [DIM_BITS-1:0] size);
    longint r;
    longint l;
    longint h;
    longint s;
    r = longint'(raw);
    l = longint'(lo);
    h = longint'(hi);
    s = longint'(size);
    if (h == l) return 0;
    return (r - l) * (s - 1) / (h - l);
  endfunction

  function automatic longint clamp_coord(longint v, logic [DIM_BITS-1:0] size);
    longint top;
    top = longint'(size);
    top = top - 1;
    if (top > COORD_MAX) top = COORD_MAX;
    if (top < 0 || v < 0) return 0;
    if (v > top) return top;
    return v;
  endfunction

  function automatic touch_point_t predict_point(logic pressed, logic [RAW_BITS-1:0] rx,
                                                 logic [RAW_BITS-1:0] ry, logic [31:0] now);
    touch_point_t p;
    logic [31:0]  elapsed;
    longint       mx;
    longint       my;
    longint       x;
    longint       y;
    longint       w;
    longint       h;
    logic         rotated;
    p = '0;
    elapsed = now - last_touch_ms;
    if (!pressed || elapsed < cal.debounce_gap) return p;
    if (rx < cal.x_low || rx > cal.x_high || ry < cal.y_low || ry > cal.y_high) return p;
    last_touch_ms = now;
    mx = scale_axis(rx, cal.x_low, cal.x_high, cal.width);
    my = scale_axis(ry, cal.y_low, cal.y_high, cal.height);
    w = longint'(cal.width);
    h = longint'(cal.height);
    case (cal.orient)
      tpcr_pkg::ORIENT_90: begin
        x = h - 1 - my;
        y = mx;
      end
      tpcr_pkg::ORIENT_180: begin
        x = w - 1 - mx;
        y = h - 1 - my;
      end
      tpcr_pkg::ORIENT_270: begin
        x = my;
        y = w - 1 - mx;
      end
      default: begin
        x = mx;
        y = my;
      end
    endcase
    rotated = (cal.orient == tpcr_pkg::ORIENT_90 || cal.orient == tpcr_pkg::ORIENT_270);
    x = clamp_coord(x, rotated ? cal.height : cal.width);
    y = clamp_coord(y, rotated ? cal.width : cal.height);
    p.valid = 1'b1;
    p.x = x[COORD_BITS-1:0];
    p.y = y[COORD_BITS-1:0];
    return p;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_points.size() == 0) begin
        report_mismatch("point with no request pending", 32'(m_tuser), 32'd0);
      end else begin
        oldest = expected_points.pop_front();
        if (m_tuser !== oldest.valid)
          report_mismatch("point_valid", 32'(m_tuser), 32'(oldest.valid));
        if (m_tdata[COORD_BITS-1:0] !== oldest.x)
          report_mismatch("screen_x", 32'(m_tdata[COORD_BITS-1:0]), 32'(oldest.x));
        if (m_tdata[2*COORD_BITS-1:COORD_BITS] !== oldest.y)
          report_mismatch("screen_y", 32'(m_tdata[2*COORD_BITS-1:COORD_BITS]),
                          32'(oldest.y));
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_sample(logic pressed, logic [RAW_BITS-1:0] rx, logic [RAW_BITS-1:0] ry,
                             logic [31:0] now);
    while ($urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= pressed;
    s_tdata  <= S_DATA_W'({now, ry, rx});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_points.push_back(predict_point(pressed, rx, ry, now));
  endtask

  // drop the request line and let the core drain before touching registers
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(tpcr_pkg::cfg_reg_t idx, logic [31:0] value, int bits);
    logic [31:0] fill;
    fill = $urandom;
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= (bits < 32) ? ((fill << bits) | value) : value;
    @(posedge clk);
  endtask

  task automatic load_config(cal_cfg_t c);
    write_reg(tpcr_pkg::REG_RAW_X_LOW, 32'(c.x_low), RAW_BITS);
    write_reg(tpcr_pkg::REG_RAW_X_HIGH, 32'(c.x_high), RAW_BITS);
    write_reg(tpcr_pkg::REG_RAW_Y_LOW, 32'(c.y_low), RAW_BITS);
    write_reg(tpcr_pkg::REG_RAW_Y_HIGH, 32'(c.y_high), RAW_BITS);
    write_reg(tpcr_pkg::REG_SCREEN_WIDTH, 32'(c.width), DIM_BITS);
    write_reg(tpcr_pkg::REG_SCREEN_HEIGHT, 32'(c.height), DIM_BITS);
    write_reg(tpcr_pkg::REG_ORIENTATION, 32'(c.orient), 2);
    write_reg(tpcr_pkg::REG_DEBOUNCE_DELAY, c.debounce_gap, 32);
    cal = c;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [RAW_BITS-1:0] pick_raw(logic [RAW_BITS-1:0] lo,
                                                   logic [RAW_BITS-1:0] hi);
    int r;
    r = $urandom_range(9);
    if (r == 0) return lo;
    if (r == 1) return hi;
    if (r == 2) return RAW_BITS'($urandom_range(4095));
    return RAW_BITS'($urandom_range(hi, lo));
  endfunction

  task automatic test_reset_defaults();
    send_sample(1'b0, 2000, 2000, 1000);
    send_sample(1'b1, 200, 200, 249);
    send_sample(1'b1, 200, 200, 250);
    send_sample(1'b1, 3900, 3900, 500);
    send_sample(1'b1, 199, 2000, 1000);
    send_sample(1'b1, 3901, 2000, 2000);
    send_sample(1'b1, 2000, 0, 3000);
    send_sample(1'b1, 4095, 4095, 4000);
    send_sample(1'b1, 2000, 2000, 32'hFFFF_FFFF);
    send_sample(1'b1, 1000, 3000, 32'h0000_00F9);
    send_sample(1'b1, 1000, 3000, 32'h0000_01F2);
    settle();
  endtask

  task automatic test_orientations();
    cal_cfg_t c;
    c = default_cal();
    c.x_low        = 0;
    c.x_high       = 4095;
    c.y_low        = 0;
    c.y_high       = 4095;
    c.debounce_gap = 0;
    for (int o = 0; o < 4; o++) begin
      c.orient = tpcr_pkg::orient_t'(o);
      load_config(c);
      send_sample(1'b1, 0, 4095, $urandom);
      send_sample(1'b1, 4095, 0, $urandom);
      settle();
    end
  endtask

  task automatic test_corner_settings();
    cal_cfg_t c;
    c = default_cal();
    c.x_low        = 1000;
    c.x_high       = 1000;
    c.y_low        = 3000;
    c.y_high       = 1000;
    c.debounce_gap = 0;
    c.orient       = tpcr_pkg::ORIENT_0;
    load_config(c);
    send_sample(1'b1, 1000, 2000, 10);
    settle();
    c.y_low = 0;
    c.y_high = 4095;
    load_config(c);
    send_sample(1'b1, 1000, 4095, 20);
    settle();
    c.x_low  = 0;
    c.x_high = 4095;
    c.width  = 0;
    c.height = 2047;
    load_config(c);
    send_sample(1'b1, 4095, 4095, 30);
    send_sample(1'b1, 0, 1, 40);
    settle();
    c.width  = 2047;
    c.height = 0;
    c.orient = tpcr_pkg::ORIENT_90;
    load_config(c);
    send_sample(1'b1, 4095, 0, 50);
    settle();
    c = default_cal();
    c.debounce_gap = 32'hFFFF_FFFF;
    load_config(c);
    send_sample(1'b1, 2000, 2000, last_touch_ms + 32'hFFFF_FFFE);
    send_sample(1'b1, 2000, 2000, last_touch_ms + 32'hFFFF_FFFF);
    settle();
  endtask

  task automatic test_random_touches();
    cal_cfg_t    c;
    logic        pressed;
    logic [11:0] rx;
    logic [11:0] ry;
    logic [31:0] now;
    for (int phase = 0; phase < 12; phase++) begin
      c.x_low        = RAW_BITS'($urandom_range(1500));
      c.x_high       = RAW_BITS'($urandom_range(4095, c.x_low));
      c.y_low        = RAW_BITS'($urandom_range(1500));
      c.y_high       = RAW_BITS'($urandom_range(4095, c.y_low));
      c.width        = DIM_BITS'($urandom_range(1024, 1));
      c.height       = DIM_BITS'($urandom_range(1024, 1));
      c.orient       = tpcr_pkg::orient_t'($urandom_range(3));
      c.debounce_gap = $urandom_range(400);
      case (phase)
        0: begin
          c.x_low = 0; c.x_high = 4095; c.y_low = 0; c.y_high = 4095;
        end
        2: c.y_high = c.y_low;
        3: begin
          c.width = 1; c.height = 1;
        end
        4: c.debounce_gap = 0;
        5: begin
          c.x_low = 3000; c.x_high = 1000;
        end
        7: c.width = 0;
        8: c.debounce_gap = $urandom;
        9: begin
          c.width = 1024; c.height = DIM_BITS'($urandom_range(2047, 1025));
        end
        default: ;
      endcase
      gap_pct   = (phase == 6) ? 0 : 19;
      stall_pct = (phase == 6) ? 0 : 19;
      load_config(c);
      for (int i = 0; i < 100; i++) begin
        if ($urandom_range(99) < 80) begin
          pressed = ($urandom_range(19) != 0);
          rx = pick_raw(cal.x_low, cal.x_high);
          ry = pick_raw(cal.y_low, cal.y_high);
          if ($urandom_range(3) == 0)
            now = last_touch_ms + cal.debounce_gap - 1 - $urandom_range(5);
          else
            now = last_touch_ms + cal.debounce_gap + $urandom_range(40);
        end else begin
          pressed = 1'($urandom_range(1));
          rx = 12'($urandom_range(4095));
          ry = 12'($urandom_range(4095));
          now = $urandom;
        end
        send_sample(pressed, rx, ry, now);
      end
      settle();
    end
    gap_pct   = 19;
    stall_pct = 19;
  endtask

  task automatic test_backpressure();
    cal_cfg_t c;
    c = default_cal();
    c.debounce_gap = 0;
    load_config(c);
    gap_pct  = 0;
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) begin
      send_sample(1'b1, RAW_BITS'($urandom_range(3900, 200)),
                  RAW_BITS'($urandom_range(3900, 200)), $urandom);
    end
    gap_pct = 19;
    settle();
  endtask

  initial begin
    cal = default_cal();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_orientations();
    test_corner_settings();
    test_random_touches();
    test_backpressure();
    settle();
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/tpcr_pkg.sv
hw/rtl/tpcr_scale_unit.sv
hw/rtl/touch_point_calibrate_rotate_core.sv
tb/tb_touch_point_calibrate_rotate_core.sv
